>>> design/grid_raycast_field_of_view_core_macros.svh
// assertion helpers used by the checker file
`ifndef GRID_RAYCAST_FIELD_OF_VIEW_CORE_MACROS_SVH
`define GRID_RAYCAST_FIELD_OF_VIEW_CORE_MACROS_SVH

// same-cycle implication on the rising clock, off during reset
`define FOV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fov check failed");

// next-cycle implication on the rising clock, off during reset
`define FOV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fov check failed");

`endif

>>> design/fov_pkg.sv
package fov_pkg;

    // signed coordinate width, holds -512..511 for all map sizes
    localparam int CW = 10;
    // bresenham error term width
    localparam int EW = 11;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [EW-1:0] t_err;

    // function codes of an input word
    localparam logic [1:0] FN_SET    = 2'd0;
    localparam logic [1:0] FN_VIEW   = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_VIEW_RADIUS = 2'd2;
    localparam logic [1:0] CFG_LIGHT_WALLS = 2'd3;

    // perimeter edge being swept by the ray targets
    typedef enum logic [1:0] {
        E_TOP    = 2'd0,
        E_RIGHT  = 2'd1,
        E_BOTTOM = 2'd2,
        E_LEFT   = 2'd3
    } t_edge;

    // sequencer to ray stepper
    typedef struct packed {
        logic init;
        logic adv;
    } t_ray_ctl;

    // ray stepper to sequencer
    typedef struct packed {
        logic   at_end;
        t_coord cx;
        t_coord cy;
        t_coord ox;
        t_coord oy;
    } t_ray_st;

endpackage

>>> design/grid_raycast_field_of_view_core.sv
// Grid field of view: a set-cell word is answered from the idle state and a query
// word after a registered memory read; a compute word first sweeps and clears the
// visibility memory, then casts one Bresenham ray per perimeter cell of the clipped
// box, and with wall lighting visits every cell of the four quadrant boxes, reading
// the in-box neighbours of each visible open cell and skipping out-of-box ones.
// All rays share the single ray stepper, and each grid memory has one read port.
// After reset a clearing pass over every grid cell runs before the first word is
// taken. The input channel stalls for the whole of a compute word.
module grid_raycast_field_of_view_core #(
    parameter int MAX_DIM = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [5:0] i_col,
    input  logic [5:0] i_row,
    input  logic       i_see_through,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_visible,
    output logic       o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    import fov_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [12:0] {
        S_RSTCLR = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_QRD    = 13'b0000000000100,
        S_VCLR   = 13'b0000000001000,
        S_RINIT  = 13'b0000000010000,
        S_RSTEP  = 13'b0000000100000,
        S_RCHK   = 13'b0000001000000,
        S_REVAL  = 13'b0000010000000,
        S_WINIT  = 13'b0000100000000,
        S_WRD    = 13'b0001000000000,
        S_WEV    = 13'b0010000000000,
        S_WNRD   = 13'b0100000000000,
        S_WNEV   = 13'b1000000000000
    } t_state;

    function automatic logic [AW-1:0] f_addr(t_coord x, t_coord y);
        return AW'(AW'($unsigned(y)) * AW'(MAX_DIM)) + AW'($unsigned(x));
    endfunction

    t_state      r_state, n_state;
    logic [6:0]  r_map_width, r_map_height, r_view_radius;
    logic        r_light_walls;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_paddr, n_paddr;
    t_coord      r_px, n_px, r_py, n_py;
    t_coord      r_xmin, n_xmin, r_xmax, n_xmax, r_ymin, n_ymin, r_ymax, n_ymax;
    logic [13:0] r_r2, n_r2;
    logic [16:0] r_d2, n_d2;
    t_edge       r_edge, n_edge;
    t_coord      r_tx, n_tx, r_ty, n_ty;
    logic [1:0]  r_q, n_q;
    t_coord      r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    t_coord      r_wx, n_wx, r_wy, n_wy;
    logic [1:0]  r_nk, n_nk;
    t_coord      r_nx, n_nx, r_ny, n_ny;
    logic        r_ov, n_ov, r_ovis, n_ovis, r_ostat, n_ostat;

    t_coord      w_eff, h_eff, in_x, in_y, rr, lo_x, hi_x, lo_y, hi_y;
    logic        acc, inb;
    t_ray_ctl    ray_ctl;
    t_ray_st     ray_st;
    logic        ray_oob;
    logic [7:0]  aox, aoy;
    t_coord      adv_tx, adv_ty;
    t_coord      wc_wx, wc_wy, nb_x, nb_y, cand_x, cand_y;
    logic [1:0]  wc_q;
    logic        wc_done, nb_xin, nb_yin, cand_ok;
    t_state      wc_next;
    logic [AW-1:0] rd_addr, clr_wa, seen_wa;
    logic        clr_we, clr_wd, clr_rd, seen_we, seen_wd, seen_rd;

    // grid memories
    fov_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_clear (
        .i_clk(i_clk), .i_we(clr_we), .i_waddr(clr_wa), .i_wdata(clr_wd),
        .i_raddr(rd_addr), .o_rdata(clr_rd)
    );
    fov_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
        .i_clk(i_clk), .i_we(seen_we), .i_waddr(seen_wa), .i_wdata(seen_wd),
        .i_raddr(rd_addr), .o_rdata(seen_rd)
    );

    // shared ray stepper
    fov_ray u_ray (
        .i_clk(i_clk), .i_ctl(ray_ctl), .i_px(r_px), .i_py(r_py),
        .i_tx(r_tx), .i_ty(r_ty), .o_st(ray_st)
    );

    // handshake and bounds of the incoming word
    always_comb begin
        w_eff = (t_coord'(r_map_width) > t_coord'(MAX_DIM)) ? t_coord'(MAX_DIM)
                                                            : t_coord'(r_map_width);
        h_eff = (t_coord'(r_map_height) > t_coord'(MAX_DIM)) ? t_coord'(MAX_DIM)
                                                             : t_coord'(r_map_height);
        in_x  = t_coord'(i_col);
        in_y  = t_coord'(i_row);
        inb   = (in_x < w_eff) && (in_y < h_eff);
        rr    = t_coord'(r_view_radius);
        lo_x  = in_x - rr;
        hi_x  = in_x + rr + t_coord'(1);
        lo_y  = in_y - rr;
        hi_y  = in_y + rr + t_coord'(1);
    end

    assign o_stall     = (r_state != S_IDLE) || (r_ov && i_stall);
    assign acc         = i_valid && !o_stall;
    assign o_cfg_ready = i_rst_n;

    // ray cell checks
    always_comb begin
        ray_oob = ray_st.cx[CW-1] || ray_st.cy[CW-1] || (ray_st.cx >= w_eff) ||
                  (ray_st.cy >= h_eff);
        aox     = ray_st.ox[CW-1] ? 8'(-ray_st.ox) : 8'(ray_st.ox);
        aoy     = ray_st.oy[CW-1] ? 8'(-ray_st.oy) : 8'(ray_st.oy);
    end

    // next perimeter target on the current edge
    always_comb begin
        adv_tx = r_tx;
        adv_ty = r_ty;
        case (r_edge)
            E_TOP:    adv_tx = r_tx + t_coord'(1);
            E_RIGHT:  adv_ty = r_ty + t_coord'(1);
            E_BOTTOM: adv_tx = r_tx - t_coord'(1);
            E_LEFT:   adv_ty = r_ty - t_coord'(1);
            default:  adv_tx = r_tx;
        endcase
    end

    // wall pass cursor and neighbour candidates
    always_comb begin
        wc_wx   = r_wx;
        wc_wy   = r_wy + t_coord'(1);
        wc_q    = r_q;
        wc_next = S_WRD;
        wc_done = 1'b0;
        if (r_wy == r_y1) begin
            wc_wy = r_y0;
            wc_wx = r_wx + t_coord'(1);
            if (r_wx == r_x1) begin
                wc_q    = r_q + 2'd1;
                wc_next = S_WINIT;
                wc_done = (r_q == 2'd3);
            end
        end
        nb_x   = r_q[0] ? r_wx + t_coord'(1) : r_wx - t_coord'(1);
        nb_y   = r_q[1] ? r_wy + t_coord'(1) : r_wy - t_coord'(1);
        nb_xin = (nb_x >= r_x0) && (nb_x <= r_x1);
        nb_yin = (nb_y >= r_y0) && (nb_y <= r_y1);
        case (r_nk)
            2'd0: begin
                cand_x = nb_x; cand_y = r_wy; cand_ok = nb_xin;
            end
            2'd1: begin
                cand_x = r_wx; cand_y = nb_y; cand_ok = nb_yin;
            end
            default: begin
                cand_x = nb_x; cand_y = nb_y; cand_ok = nb_xin && nb_yin;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_paddr = r_paddr;
        n_px    = r_px;
        n_py    = r_py;
        n_xmin  = r_xmin;
        n_xmax  = r_xmax;
        n_ymin  = r_ymin;
        n_ymax  = r_ymax;
        n_r2    = r_r2;
        n_d2    = r_d2;
        n_edge  = r_edge;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_q     = r_q;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_y0    = r_y0;
        n_y1    = r_y1;
        n_wx    = r_wx;
        n_wy    = r_wy;
        n_nk    = r_nk;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_ov    = r_ov && i_stall;
        n_ovis  = r_ovis;
        n_ostat = r_ostat;
        ray_ctl = '0;
        rd_addr = f_addr(in_x, in_y);
        clr_we  = 1'b0;
        clr_wa  = f_addr(in_x, in_y);
        clr_wd  = i_see_through;
        seen_we = 1'b0;
        seen_wa = f_addr(ray_st.cx, ray_st.cy);
        seen_wd = 1'b1;
        case (r_state)
            S_RSTCLR: begin
                clr_we  = 1'b1;
                clr_wa  = r_cnt;
                clr_wd  = 1'b0;
                seen_we = 1'b1;
                seen_wa = r_cnt;
                seen_wd = 1'b0;
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_ov    = 1'b1;
                    n_ovis  = 1'b0;
                    n_ostat = 1'b0;
                    case (i_func)
                        FN_SET: begin
                            n_ostat = !inb;
                            clr_we  = inb;
                        end
                        FN_VIEW: begin
                            n_ostat = !inb;
                            if (inb) begin
                                n_ov    = 1'b0;
                                n_px    = in_x;
                                n_py    = in_y;
                                n_paddr = f_addr(in_x, in_y);
                                n_cnt   = '0;
                                n_r2    = 14'(r_view_radius * r_view_radius);
                                n_xmin  = (rr != '0 && lo_x > t_coord'(0)) ? lo_x : t_coord'(0);
                                n_ymin  = (rr != '0 && lo_y > t_coord'(0)) ? lo_y : t_coord'(0);
                                n_xmax  = (rr != '0 && hi_x < w_eff) ? hi_x : w_eff;
                                n_ymax  = (rr != '0 && hi_y < h_eff) ? hi_y : h_eff;
                                n_state = S_VCLR;
                            end
                        end
                        FN_QUERY: begin
                            n_ostat = !inb;
                            if (inb) begin
                                n_ov    = 1'b0;
                                n_state = S_QRD;
                            end
                        end
                        default: n_ostat = 1'b0;
                    endcase
                end
            end
            S_QRD: begin
                n_ov    = 1'b1;
                n_ovis  = seen_rd;
                n_ostat = 1'b0;
                n_state = S_IDLE;
            end
            // clear visibility, marking the viewpoint on the way
            S_VCLR: begin
                seen_we = 1'b1;
                seen_wa = r_cnt;
                seen_wd = (r_cnt == r_paddr);
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_edge  = E_TOP;
                    n_tx    = r_xmin;
                    n_ty    = r_ymin;
                    n_state = S_RINIT;
                end
            end
            // start a ray, move to the next edge, or end the ray pass
            S_RINIT: begin
                case (r_edge)
                    E_TOP: begin
                        if (r_tx < r_xmax) begin
                            ray_ctl.init = 1'b1;
                            n_state      = S_RSTEP;
                        end else begin
                            n_edge = E_RIGHT;
                            n_tx   = r_xmax - t_coord'(1);
                            n_ty   = r_ymin + t_coord'(1);
                        end
                    end
                    E_RIGHT: begin
                        if (r_ty < r_ymax) begin
                            ray_ctl.init = 1'b1;
                            n_state      = S_RSTEP;
                        end else begin
                            n_edge = E_BOTTOM;
                            n_tx   = r_xmax - t_coord'(2);
                            n_ty   = r_ymax - t_coord'(1);
                        end
                    end
                    E_BOTTOM: begin
                        if (r_tx >= r_xmin) begin
                            ray_ctl.init = 1'b1;
                            n_state      = S_RSTEP;
                        end else begin
                            n_edge = E_LEFT;
                            n_tx   = r_xmin;
                            n_ty   = r_ymax - t_coord'(2);
                        end
                    end
                    default: begin
                        if (r_ty > r_ymin) begin
                            ray_ctl.init = 1'b1;
                            n_state      = S_RSTEP;
                        end else if (r_light_walls) begin
                            n_q     = 2'd0;
                            n_state = S_WINIT;
                        end else begin
                            n_ov    = 1'b1;
                            n_ovis  = 1'b0;
                            n_ostat = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_RSTEP: begin
                if (ray_st.at_end) begin
                    n_tx    = adv_tx;
                    n_ty    = adv_ty;
                    n_state = S_RINIT;
                end else begin
                    ray_ctl.adv = 1'b1;
                    n_state     = S_RCHK;
                end
            end
            S_RCHK: begin
                rd_addr = f_addr(ray_st.cx, ray_st.cy);
                n_d2    = {1'b0, 16'(aox * aox)} + {1'b0, 16'(aoy * aoy)};
                if (ray_oob) begin
                    n_tx    = adv_tx;
                    n_ty    = adv_ty;
                    n_state = S_RINIT;
                end else begin
                    n_state = S_REVAL;
                end
            end
            S_REVAL: begin
                if (r_r2 != '0 && r_d2 > {3'b000, r_r2}) begin
                    n_tx    = adv_tx;
                    n_ty    = adv_ty;
                    n_state = S_RINIT;
                end else if (!clr_rd) begin
                    seen_we = r_light_walls;
                    n_tx    = adv_tx;
                    n_ty    = adv_ty;
                    n_state = S_RINIT;
                end else begin
                    seen_we = 1'b1;
                    n_state = S_RSTEP;
                end
            end
            // quadrant box of the wall pass
            S_WINIT: begin
                n_x0    = r_q[0] ? r_px : r_xmin;
                n_x1    = r_q[0] ? r_xmax - t_coord'(1) : r_px;
                n_y0    = r_q[1] ? r_py : r_ymin;
                n_y1    = r_q[1] ? r_ymax - t_coord'(1) : r_py;
                n_wx    = r_q[0] ? r_px : r_xmin;
                n_wy    = r_q[1] ? r_py : r_ymin;
                n_state = S_WRD;
            end
            S_WRD: begin
                rd_addr = f_addr(r_wx, r_wy);
                n_state = S_WEV;
            end
            S_WEV: begin
                if (seen_rd && clr_rd) begin
                    n_nk    = 2'd0;
                    n_state = S_WNRD;
                end else begin
                    n_wx = wc_wx;
                    n_wy = wc_wy;
                    n_q  = wc_q;
                    if (wc_done) begin
                        n_ov    = 1'b1;
                        n_ovis  = 1'b0;
                        n_ostat = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = wc_next;
                    end
                end
            end
            S_WNRD: begin
                rd_addr = f_addr(cand_x, cand_y);
                n_nx    = cand_x;
                n_ny    = cand_y;
                if (cand_ok) begin
                    n_state = S_WNEV;
                end else if (r_nk != 2'd2) begin
                    n_nk = r_nk + 2'd1;
                end else begin
                    n_wx = wc_wx;
                    n_wy = wc_wy;
                    n_q  = wc_q;
                    if (wc_done) begin
                        n_ov    = 1'b1;
                        n_ovis  = 1'b0;
                        n_ostat = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = wc_next;
                    end
                end
            end
            S_WNEV: begin
                seen_wa = f_addr(r_nx, r_ny);
                seen_we = !clr_rd;
                if (r_nk != 2'd2) begin
                    n_nk    = r_nk + 2'd1;
                    n_state = S_WNRD;
                end else begin
                    n_wx = wc_wx;
                    n_wy = wc_wy;
                    n_q  = wc_q;
                    if (wc_done) begin
                        n_ov    = 1'b1;
                        n_ovis  = 1'b0;
                        n_ostat = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = wc_next;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RSTCLR;
            r_cnt         <= '0;
            r_ov          <= 1'b0;
            r_map_width   <= 7'd64;
            r_map_height  <= 7'd64;
            r_view_radius <= 7'd0;
            r_light_walls <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data;
                    CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data;
                    CFG_VIEW_RADIUS: r_view_radius <= i_cfg_data;
                    default:         r_light_walls <= i_cfg_data[0];
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_paddr <= n_paddr;
        r_px    <= n_px;
        r_py    <= n_py;
        r_xmin  <= n_xmin;
        r_xmax  <= n_xmax;
        r_ymin  <= n_ymin;
        r_ymax  <= n_ymax;
        r_r2    <= n_r2;
        r_d2    <= n_d2;
        r_edge  <= n_edge;
        r_tx    <= n_tx;
        r_ty    <= n_ty;
        r_q     <= n_q;
        r_x0    <= n_x0;
        r_x1    <= n_x1;
        r_y0    <= n_y0;
        r_y1    <= n_y1;
        r_wx    <= n_wx;
        r_wy    <= n_wy;
        r_nk    <= n_nk;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_ovis  <= n_ovis;
        r_ostat <= n_ostat;
    end

    assign o_valid   = r_ov;
    assign o_visible = r_ovis;
    assign o_status  = r_ostat;
endmodule

>>> design/fov_ram.sv
module fov_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/fov_ray.sv
module fov_ray (
    input  logic              i_clk,
    input  fov_pkg::t_ray_ctl i_ctl,
    input  fov_pkg::t_coord   i_px,
    input  fov_pkg::t_coord   i_py,
    input  fov_pkg::t_coord   i_tx,
    input  fov_pkg::t_coord   i_ty,
    output fov_pkg::t_ray_st  o_st
);
    import fov_pkg::*;

    t_coord r_cx, n_cx;
    t_coord r_cy, n_cy;
    t_coord r_sx, n_sx;
    t_coord r_sy, n_sy;
    t_coord r_adx, n_adx;
    t_coord r_ady, n_ady;
    t_coord r_tx, n_tx;
    t_coord r_ty, n_ty;
    t_err   r_err, n_err;
    logic   r_major, n_major;

    t_coord dx, dy, adx, ady;
    t_err   e_one;

    // direction set-up from viewpoint to target
    always_comb begin
        dx  = i_tx - i_px;
        dy  = i_ty - i_py;
        adx = dx[CW-1] ? -dx : dx;
        ady = dy[CW-1] ? -dy : dy;
    end

    // one bresenham step per advance
    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_adx   = r_adx;
        n_ady   = r_ady;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_err   = r_err;
        n_major = r_major;
        e_one   = r_err;
        if (i_ctl.init) begin
            n_cx    = i_px;
            n_cy    = i_py;
            n_tx    = i_tx;
            n_ty    = i_ty;
            n_adx   = adx;
            n_ady   = ady;
            n_sx    = (dx == '0) ? t_coord'(0) : (dx[CW-1] ? t_coord'(-1) : t_coord'(1));
            n_sy    = (dy == '0) ? t_coord'(0) : (dy[CW-1] ? t_coord'(-1) : t_coord'(1));
            n_major = adx > ady;
            n_err   = (adx > ady) ? t_err'(adx) : t_err'(ady);
        end else if (i_ctl.adv) begin
            if (r_major) begin
                n_cx  = r_cx + r_sx;
                e_one = r_err - t_err'(r_ady) - t_err'(r_ady);
                if (e_one[EW-1]) begin
                    n_cy  = r_cy + r_sy;
                    e_one = e_one + t_err'(r_adx) + t_err'(r_adx);
                end
            end else begin
                n_cy  = r_cy + r_sy;
                e_one = r_err - t_err'(r_adx) - t_err'(r_adx);
                if (e_one[EW-1]) begin
                    n_cx  = r_cx + r_sx;
                    e_one = e_one + t_err'(r_ady) + t_err'(r_ady);
                end
            end
            n_err = e_one;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_adx   <= n_adx;
        r_ady   <= n_ady;
        r_tx    <= n_tx;
        r_ty    <= n_ty;
        r_err   <= n_err;
        r_major <= n_major;
    end

    // current cell and offset from the viewpoint
    assign o_st.at_end = r_major ? (r_cx == r_tx) : (r_cy == r_ty);
    assign o_st.cx     = r_cx;
    assign o_st.cy     = r_cy;
    assign o_st.ox     = r_cx - i_px;
    assign o_st.oy     = r_cy - i_py;
endmodule

>>> design/fov_checker.sv
`include "grid_raycast_field_of_view_core_macros.svh"

module fov_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_visible,
    input logic       o_status
);
    // a stalled result word holds
    `FOV_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable({o_visible, o_status}))
    // an ignored word never reports a visible cell
    `FOV_ASSERT_SAME(a_status_vis, o_valid && o_status, !o_visible)
    // no word is taken while a result sits blocked
    `FOV_ASSERT_SAME(a_no_overrun, i_valid && !o_stall, !(o_valid && i_stall))
    // after a word is taken the block is busy or shows its result
    `FOV_ASSERT_NEXT(a_acc_busy, i_valid && !o_stall, o_stall || o_valid)
endmodule

bind grid_raycast_field_of_view_core fov_checker u_fov_checker (.*);
